// File: design/stt_pkg.sv
// Shared constants, keyword tables and types of the source text tokenizer.
`timescale 1ns / 1ps
package stt_pkg;

   // Keyword table dimensions.
   localparam int KW_COUNT   = 12;
   localparam int KW_MAX_LEN = 6;
   localparam int KW_POS_W   = $clog2(KW_MAX_LEN);

   // Keyword spellings, zero padded past their length.
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{"s", "t", "a", "r", "t", 8'h00},
      '{"e", "n", "d", 8'h00, 8'h00, 8'h00},
      '{"p", "r", "i", "n", "t", 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00},
      '{"s", "t", "r", "i", "n", "g"},
      '{"f", "u", "n", "c", "t", 8'h00},
      '{"r", "e", "t", "u", "r", "n"},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd5, 3'd3, 3'd5, 3'd3, 3'd5, 3'd6, 3'd5, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3
   };

   // Lexer mode codes.
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_IDENT = 3'd1;
   localparam logic [2:0] MODE_NUM   = 3'd2;
   localparam logic [2:0] MODE_STR   = 3'd3;
   localparam logic [2:0] MODE_ESC   = 3'd4;
   localparam logic [2:0] MODE_CMT   = 3'd5;
   localparam logic [2:0] MODE_OP    = 3'd6;

   // Result types.
   localparam logic [1:0] RT_VALUE = 2'd0;
   localparam logic [1:0] RT_END   = 2'd1;
   localparam logic [1:0] RT_ERROR = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
   localparam logic [1:0] ERR_LONE_OP      = 2'd2;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd3;

   // Token kinds.
   localparam logic [5:0] KIND_NONE     = 6'd0;
   localparam logic [5:0] KIND_IDENT    = 6'd12;
   localparam logic [5:0] KIND_INT      = 6'd13;
   localparam logic [5:0] KIND_FLOAT    = 6'd14;
   localparam logic [5:0] KIND_STRING   = 6'd15;
   localparam logic [5:0] KIND_COMMA    = 6'd16;
   localparam logic [5:0] KIND_PLUS     = 6'd17;
   localparam logic [5:0] KIND_PLUS_EQ  = 6'd18;
   localparam logic [5:0] KIND_MINUS    = 6'd19;
   localparam logic [5:0] KIND_MINUS_EQ = 6'd20;
   localparam logic [5:0] KIND_STAR     = 6'd21;
   localparam logic [5:0] KIND_STAR_EQ  = 6'd22;
   localparam logic [5:0] KIND_SLASH    = 6'd23;
   localparam logic [5:0] KIND_SLASH_EQ = 6'd24;
   localparam logic [5:0] KIND_LPAREN   = 6'd25;
   localparam logic [5:0] KIND_RPAREN   = 6'd26;
   localparam logic [5:0] KIND_LBRACE   = 6'd27;
   localparam logic [5:0] KIND_RBRACE   = 6'd28;
   localparam logic [5:0] KIND_SEMI     = 6'd29;
   localparam logic [5:0] KIND_ASSIGN   = 6'd30;
   localparam logic [5:0] KIND_EQ       = 6'd31;
   localparam logic [5:0] KIND_GT       = 6'd32;
   localparam logic [5:0] KIND_GE       = 6'd33;
   localparam logic [5:0] KIND_LT       = 6'd34;
   localparam logic [5:0] KIND_NE_ANGLE = 6'd35;
   localparam logic [5:0] KIND_LE       = 6'd36;
   localparam logic [5:0] KIND_AND      = 6'd37;
   localparam logic [5:0] KIND_OR       = 6'd38;
   localparam logic [5:0] KIND_NOT      = 6'd39;
   localparam logic [5:0] KIND_NOT_EQ   = 6'd40;
   localparam logic [5:0] KIND_PERCENT  = 6'd41;
   localparam logic [5:0] KIND_EOF      = 6'd42;

   // Result queue depth.
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // One result item as it sits in the queue.
   typedef struct packed {
      logic       last;
      logic [1:0] error_code;
      logic [5:0] token_kind;
      logic [7:0] value_byte;
      logic [1:0] result_type;
   } rsp_item_type;

endpackage

// File: design/source_text_tokenizer_top.sv
// Byte-serial tokenizer: input register, token logic, result queue.
//
//  Channel | Direction | Handshake              | Payload
//  req     | in        | req_tvalid/req_tready  | tdata: in_byte; tlast: end_of_text
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: value_byte, token_kind,
//          |           |                        |   error_code; tuser: result_type;
//          |           |                        |   tlast: last
//
// One byte is accepted per cycle while the queue has room for two results. A byte
// waits in the input register, then the token logic updates the lexer state and
// writes zero, one or two results into a four-entry result queue.
// Output drains one result per cycle while rsp_tready is high; a byte that causes two
// results needs two transfers. Reset puts the lexer in idle mode and empties the queue.
// A stalled output only blocks input once the queue lacks room for two results.
`timescale 1ns / 1ps
module source_text_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] value_byte, [13:8] token_kind,
                                    // [15:14] error_code
   output logic [1:0]  rsp_tuser,   // [1:0] result_type
   output logic        rsp_tlast    // last
);
   import stt_pkg::*;

   // Input register.
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;
   logic       advance;

   // Lexer state.
   logic [2:0]          mode_ff, mode_in;
   logic [7:0]          pend_ff, pend_in;
   logic                point_ff, point_in;
   logic [KW_COUNT-1:0] mask_ff, mask_in;
   logic [2:0]          len_ff, len_in;
   logic                fin_ff, fin_in;

   // Result queue.
   rsp_item_type        fifo_mem [FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pop;
   logic [1:0]          push_n;
   rsp_item_type        wr0, wr1;

   // Token logic signals.
   logic                 close_vld, main_vld;
   rsp_item_type         close_res, main_res;
   logic                 use_idle;
   logic                 idle_vld;
   rsp_item_type         idle_res;
   logic [2:0]           idle_mode;
   logic [7:0]           idle_pend;
   logic [KW_COUNT-1:0]  match_first, match_cur;
   logic [KW_POS_W-1:0]  cur_pos;
   logic [5:0]           word_kind;
   logic [6:0]           pair;
   logic [7:0]           c;
   logic                 c_alpha, c_digit, c_space, c_word;

   function automatic rsp_item_type mk_res(logic [1:0] rtype, logic [7:0] val,
                                           logic [5:0] kind, logic [1:0] err);
      rsp_item_type r;
      r.result_type = rtype;
      r.value_byte  = val;
      r.token_kind  = kind;
      r.error_code  = err;
      r.last        = 1'b0;
      return r;
   endfunction

   // Kind of a one-character operator that has no second character.
   function automatic logic [5:0] single_kind(logic [7:0] p);
      logic [5:0] k;
      case (p)
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         "=":     k = KIND_ASSIGN;
         ">":     k = KIND_GT;
         "<":     k = KIND_LT;
         "!":     k = KIND_NOT;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   // Two-character operator: bit 6 flags a match, the low bits hold the kind.
   function automatic logic [6:0] pair_kind(logic [7:0] p, logic [7:0] ch);
      logic [6:0] k;
      k = {1'b0, KIND_NONE};
      if (ch == "=") begin
         case (p)
            "+":     k = {1'b1, KIND_PLUS_EQ};
            "-":     k = {1'b1, KIND_MINUS_EQ};
            "*":     k = {1'b1, KIND_STAR_EQ};
            "/":     k = {1'b1, KIND_SLASH_EQ};
            "=":     k = {1'b1, KIND_EQ};
            ">":     k = {1'b1, KIND_GE};
            "<":     k = {1'b1, KIND_LE};
            "!":     k = {1'b1, KIND_NOT_EQ};
            default: k = {1'b0, KIND_NONE};
         endcase
      end else if (p == "<" && ch == ">") begin
         k = {1'b1, KIND_NE_ANGLE};
      end else if (p == "&" && ch == "&") begin
         k = {1'b1, KIND_AND};
      end else if (p == "|" && ch == "|") begin
         k = {1'b1, KIND_OR};
      end
      return k;
   endfunction

   function automatic logic [7:0] decode_escape(logic [7:0] ch);
      logic [7:0] v;
      case (ch)
         "n":     v = 8'd10;
         "r":     v = 8'd13;
         "t":     v = 8'd9;
         "\\":    v = "\\";
         "\"":    v = "\"";
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // Input handshake: the register moves on when the queue has room for two results.
   assign advance    = in_vld_ff && (cnt_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   // Byte classes.
   assign c       = in_byte_ff;
   assign c_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   assign c_digit = (c >= "0" && c <= "9");
   assign c_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
   assign c_word  = c_alpha || c_digit || (c == "_");

   // Keyword match of this byte at the first and at the current position.
   assign cur_pos = (len_ff < 3'(KW_MAX_LEN)) ? KW_POS_W'(len_ff) : '0;
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         match_first[k] = (KW_TEXT[k][0] == c);
         match_cur[k]   = (KW_TEXT[k][cur_pos] == c);
      end
   end

   // Kind of the identifier that ends now: lowest matching keyword of the right length.
   always_comb begin
      word_kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (mask_ff[k] && KW_LEN[k] == len_ff) begin
            word_kind = 6'(k);
         end
      end
   end

   assign pair = pair_kind(pend_ff, c);

   // A byte seen from the idle mode, with the token state cleared.
   always_comb begin
      idle_vld  = 1'b0;
      idle_res  = mk_res(RT_VALUE, 8'h00, KIND_NONE, ERR_NONE);
      idle_mode = MODE_IDLE;
      idle_pend = 8'h00;
      if (c_alpha || c == "_") begin
         idle_vld  = 1'b1;
         idle_res  = mk_res(RT_VALUE, c, KIND_NONE, ERR_NONE);
         idle_mode = MODE_IDENT;
      end else if (c_space) begin
         idle_mode = MODE_IDLE;
      end else if (c_digit) begin
         idle_vld  = 1'b1;
         idle_res  = mk_res(RT_VALUE, c, KIND_NONE, ERR_NONE);
         idle_mode = MODE_NUM;
      end else if (c == "\"") begin
         idle_mode = MODE_STR;
      end else if (c == "#") begin
         idle_mode = MODE_CMT;
      end else begin
         case (c)
            ",": begin
               idle_vld = 1'b1;
               idle_res = mk_res(RT_END, 8'h00, KIND_COMMA, ERR_NONE);
            end
            "(": begin
               idle_vld = 1'b1;
               idle_res = mk_res(RT_END, 8'h00, KIND_LPAREN, ERR_NONE);
            end
            ")": begin
               idle_vld = 1'b1;
               idle_res = mk_res(RT_END, 8'h00, KIND_RPAREN, ERR_NONE);
            end
            "{": begin
               idle_vld = 1'b1;
               idle_res = mk_res(RT_END, 8'h00, KIND_LBRACE, ERR_NONE);
            end
            "}": begin
               idle_vld = 1'b1;
               idle_res = mk_res(RT_END, 8'h00, KIND_RBRACE, ERR_NONE);
            end
            ";": begin
               idle_vld = 1'b1;
               idle_res = mk_res(RT_END, 8'h00, KIND_SEMI, ERR_NONE);
            end
            "%": begin
               idle_vld = 1'b1;
               idle_res = mk_res(RT_END, 8'h00, KIND_PERCENT, ERR_NONE);
            end
            "+", "-", "*", "/", "=", ">", "<", "&", "|", "!": begin
               idle_mode = MODE_OP;
               idle_pend = c;
            end
            default: begin
               idle_vld = 1'b1;
               idle_res = mk_res(RT_ERROR, c, KIND_NONE, ERR_UNEXPECTED);
            end
         endcase
      end
   end

   // Main token logic: a closing result, then the result of the byte itself.
   always_comb begin
      close_vld = 1'b0;
      close_res = mk_res(RT_VALUE, 8'h00, KIND_NONE, ERR_NONE);
      main_vld  = 1'b0;
      main_res  = mk_res(RT_VALUE, 8'h00, KIND_NONE, ERR_NONE);
      use_idle  = 1'b0;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      point_in  = point_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      fin_in    = fin_ff;
      if (fin_ff) begin
         main_vld = 1'b1;
         main_res = mk_res(RT_END, 8'h00, KIND_EOF, ERR_NONE);
      end else if (in_eot_ff) begin
         case (mode_ff)
            MODE_IDENT: begin
               close_vld = 1'b1;
               close_res = mk_res(RT_END, 8'h00, word_kind, ERR_NONE);
            end
            MODE_NUM: begin
               close_vld = 1'b1;
               close_res = mk_res(RT_END, 8'h00, point_ff ? KIND_FLOAT : KIND_INT,
                                  ERR_NONE);
            end
            MODE_STR, MODE_ESC: begin
               close_vld = 1'b1;
               close_res = mk_res(RT_ERROR, 8'h00, KIND_NONE, ERR_UNTERMINATED);
            end
            MODE_OP: begin
               close_vld = 1'b1;
               if (pend_ff == "&" || pend_ff == "|") begin
                  close_res = mk_res(RT_ERROR, pend_ff, KIND_NONE, ERR_LONE_OP);
               end else begin
                  close_res = mk_res(RT_END, 8'h00, single_kind(pend_ff), ERR_NONE);
               end
            end
            default: begin
               close_vld = 1'b0;
            end
         endcase
         main_vld = 1'b1;
         main_res = mk_res(RT_END, 8'h00, KIND_EOF, ERR_NONE);
         mode_in  = MODE_IDLE;
         pend_in  = 8'h00;
         point_in = 1'b0;
         mask_in  = '1;
         len_in   = 3'd0;
         fin_in   = 1'b1;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (c_word) begin
                  main_vld = 1'b1;
                  main_res = mk_res(RT_VALUE, c, KIND_NONE, ERR_NONE);
                  mask_in  = (len_ff >= 3'(KW_MAX_LEN)) ? '0 : (mask_ff & match_cur);
                  len_in   = (len_ff == 3'd7) ? len_ff : len_ff + 3'd1;
               end else begin
                  close_vld = 1'b1;
                  close_res = mk_res(RT_END, 8'h00, word_kind, ERR_NONE);
                  use_idle  = 1'b1;
               end
            end
            MODE_NUM: begin
               if (c_digit || c == ".") begin
                  main_vld = 1'b1;
                  main_res = mk_res(RT_VALUE, c, KIND_NONE, ERR_NONE);
                  point_in = point_ff || (c == ".");
               end else begin
                  close_vld = 1'b1;
                  close_res = mk_res(RT_END, 8'h00, point_ff ? KIND_FLOAT : KIND_INT,
                                     ERR_NONE);
                  use_idle  = 1'b1;
               end
            end
            MODE_STR: begin
               if (c == "\"") begin
                  main_vld = 1'b1;
                  main_res = mk_res(RT_END, 8'h00, KIND_STRING, ERR_NONE);
                  mode_in  = MODE_IDLE;
               end else if (c == "\\") begin
                  mode_in = MODE_ESC;
               end else begin
                  main_vld = 1'b1;
                  main_res = mk_res(RT_VALUE, c, KIND_NONE, ERR_NONE);
               end
            end
            MODE_ESC: begin
               main_vld = 1'b1;
               main_res = mk_res(RT_VALUE, decode_escape(c), KIND_NONE, ERR_NONE);
               mode_in  = MODE_STR;
            end
            MODE_CMT: begin
               if (c == 8'd13 || c == 8'd10) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_OP: begin
               if (pair[6]) begin
                  main_vld = 1'b1;
                  main_res = mk_res(RT_END, 8'h00, pair[5:0], ERR_NONE);
                  mode_in  = MODE_IDLE;
                  pend_in  = 8'h00;
               end else begin
                  close_vld = 1'b1;
                  if (pend_ff == "&" || pend_ff == "|") begin
                     close_res = mk_res(RT_ERROR, pend_ff, KIND_NONE, ERR_LONE_OP);
                  end else begin
                     close_res = mk_res(RT_END, 8'h00, single_kind(pend_ff), ERR_NONE);
                  end
                  use_idle = 1'b1;
               end
            end
            default: begin
               use_idle = 1'b1;
            end
         endcase
         // The byte starts a new token from a cleared state.
         if (use_idle) begin
            main_vld = idle_vld;
            main_res = idle_res;
            mode_in  = idle_mode;
            pend_in  = idle_pend;
            point_in = 1'b0;
            mask_in  = (idle_mode == MODE_IDENT) ? match_first : '1;
            len_in   = (idle_mode == MODE_IDENT) ? 3'd1 : 3'd0;
         end
      end
   end

   // Lexer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= 8'h00;
         point_ff <= 1'b0;
         mask_ff  <= '1;
         len_ff   <= 3'd0;
         fin_ff   <= 1'b0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         point_ff <= point_in;
         mask_ff  <= mask_in;
         len_ff   <= len_in;
         fin_ff   <= fin_in;
      end
   end

   // Pack the results of this transaction for the queue.
   always_comb begin
      push_n = advance ? (2'(close_vld) + 2'(main_vld)) : 2'd0;
      wr0    = close_vld ? close_res : main_res;
      wr0.last = !(close_vld && main_vld);
      wr1    = main_res;
      wr1.last = 1'b1;
   end

   // Result queue pointers and fill count.
   assign pop       = rsp_tvalid && rsp_tready;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in    = cnt_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_mem[wr_ptr_ff] <= wr0;
      end
      if (push_n == 2'd2) begin
         fifo_mem[wr_ptr_ff + PTR_W'(1)] <= wr1;
      end
   end

   // Output side.
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {fifo_mem[rd_ptr_ff].error_code, fifo_mem[rd_ptr_ff].token_kind,
                        fifo_mem[rd_ptr_ff].value_byte};
   assign rsp_tuser  = fifo_mem[rd_ptr_ff].result_type;
   assign rsp_tlast  = fifo_mem[rd_ptr_ff].last;

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // A pending operator byte exists only in operator mode.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_OP) |-> (pend_ff == 8'h00))
      else $error("stale pending operator");

   // Once end of text is taken, the stream stays finished.
   assert property (@(posedge clock) disable iff (reset) fin_ff |=> fin_ff)
      else $error("finished flag dropped");

   // An open identifier has seen at least one byte.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDENT) |-> (len_ff != 3'd0))
      else $error("identifier mode with zero length");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of the source text tokenizer: random token streams, scored results.
`timescale 1ns / 1ps
module tb_top;
   import stt_pkg::*;

   // Source byte as queued for the driver.
   typedef struct {
      logic [7:0] in_byte;
      logic       end_of_text;
   } src_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   src_item_type pending_bytes[$];
   rsp_item_type token_results[$];
   rsp_item_type step_results[$];
   int           accepted_count = 0;
   int           total_bytes = 1 << 30;
   int           fail_count = 0;
   int           send_gap = 0;
   int           stall_left = 0;

   // Scanner state of the predictor.
   logic [2:0]          lex_mode;
   logic [7:0]          pend_op;
   logic                has_point;
   logic [KW_COUNT-1:0] kw_mask;
   logic [2:0]          id_len;
   logic                text_done;

   source_text_tokenizer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Token predictor
   // ---------------------------------------------------------------
   function automatic void put_result(logic [1:0] rt, logic [7:0] val, logic [5:0] kind,
                                      logic [1:0] err);
      rsp_item_type r;
      r.result_type = rt;
      r.value_byte  = val;
      r.token_kind  = kind;
      r.error_code  = err;
      r.last        = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void clear_token_state();
      kw_mask   = '1;
      id_len    = 3'd0;
      has_point = 1'b0;
      pend_op   = 8'h00;
      lex_mode  = MODE_IDLE;
   endfunction

   // Narrow the keyword candidates by one more identifier byte.
   function automatic void ident_take(logic [7:0] c);
      if (id_len >= KW_MAX_LEN) begin
         kw_mask = '0;
      end else begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (KW_TEXT[k][id_len] != c) kw_mask[k] = 1'b0;
         end
      end
      if (id_len < 3'd7) id_len = id_len + 3'd1;
      put_result(RT_VALUE, c, KIND_NONE, ERR_NONE);
   endfunction

   // First keyword still matching with the exact length wins.
   function automatic void close_word();
      logic [5:0] kind;
      logic       found;
      kind  = KIND_IDENT;
      found = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!found && kw_mask[k] && KW_LEN[k] == id_len) begin
            kind  = 6'(k);
            found = 1'b1;
         end
      end
      put_result(RT_END, 8'h00, kind, ERR_NONE);
      clear_token_state();
   endfunction

   function automatic void close_number();
      put_result(RT_END, 8'h00, has_point ? KIND_FLOAT : KIND_INT, ERR_NONE);
      clear_token_state();
   endfunction

   // A pending operator that got no second byte stands alone.
   function automatic void flush_pending_op();
      logic [5:0] kind;
      if (pend_op == "&" || pend_op == "|") begin
         put_result(RT_ERROR, pend_op, KIND_NONE, ERR_LONE_OP);
      end else begin
         case (pend_op)
            "+":     kind = KIND_PLUS;
            "-":     kind = KIND_MINUS;
            "*":     kind = KIND_STAR;
            "/":     kind = KIND_SLASH;
            "=":     kind = KIND_ASSIGN;
            ">":     kind = KIND_GT;
            "<":     kind = KIND_LT;
            "!":     kind = KIND_NOT;
            default: kind = KIND_NONE;
         endcase
         put_result(RT_END, 8'h00, kind, ERR_NONE);
      end
      clear_token_state();
   endfunction

   // A byte seen with no token open.
   function automatic void idle_take(logic [7:0] c);
      if (c == "_" || is_letter(c)) begin
         clear_token_state();
         lex_mode = MODE_IDENT;
         ident_take(c);
      end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
         // whitespace is skipped
      end else if (is_digit(c)) begin
         lex_mode  = MODE_NUM;
         has_point = 1'b0;
         put_result(RT_VALUE, c, KIND_NONE, ERR_NONE);
      end else if (c == "\"") begin
         lex_mode = MODE_STR;
      end else if (c == "#") begin
         lex_mode = MODE_CMT;
      end else begin
         case (c)
            ",": put_result(RT_END, 8'h00, KIND_COMMA, ERR_NONE);
            "(": put_result(RT_END, 8'h00, KIND_LPAREN, ERR_NONE);
            ")": put_result(RT_END, 8'h00, KIND_RPAREN, ERR_NONE);
            "{": put_result(RT_END, 8'h00, KIND_LBRACE, ERR_NONE);
            "}": put_result(RT_END, 8'h00, KIND_RBRACE, ERR_NONE);
            ";": put_result(RT_END, 8'h00, KIND_SEMI, ERR_NONE);
            "%": put_result(RT_END, 8'h00, KIND_PERCENT, ERR_NONE);
            "+", "-", "*", "/", "=", ">", "<", "&", "|", "!": begin
               lex_mode = MODE_OP;
               pend_op  = c;
            end
            default: put_result(RT_ERROR, c, KIND_NONE, ERR_UNEXPECTED);
         endcase
      end
   endfunction

   // Work out the results of one accepted transaction and queue them.
   function automatic void lex_step(logic [7:0] c, logic eot);
      logic [5:0] pair_kind;
      logic       paired;
      logic [7:0] esc_val;
      rsp_item_type r;
      if (text_done) begin
         put_result(RT_END, 8'h00, KIND_EOF, ERR_NONE);
      end else if (eot) begin
         case (lex_mode)
            MODE_IDENT:         close_word();
            MODE_NUM:           close_number();
            MODE_STR, MODE_ESC: put_result(RT_ERROR, 8'h00, KIND_NONE, ERR_UNTERMINATED);
            MODE_OP:            flush_pending_op();
            default:            ;
         endcase
         clear_token_state();
         text_done = 1'b1;
         put_result(RT_END, 8'h00, KIND_EOF, ERR_NONE);
      end else begin
         case (lex_mode)
            MODE_IDENT: begin
               if (c == "_" || is_letter(c) || is_digit(c)) begin
                  ident_take(c);
               end else begin
                  close_word();
                  idle_take(c);
               end
            end
            MODE_NUM: begin
               if (is_digit(c) || c == ".") begin
                  if (c == ".") has_point = 1'b1;
                  put_result(RT_VALUE, c, KIND_NONE, ERR_NONE);
               end else begin
                  close_number();
                  idle_take(c);
               end
            end
            MODE_STR: begin
               if (c == "\"") begin
                  put_result(RT_END, 8'h00, KIND_STRING, ERR_NONE);
                  clear_token_state();
               end else if (c == "\\") begin
                  lex_mode = MODE_ESC;
               end else begin
                  put_result(RT_VALUE, c, KIND_NONE, ERR_NONE);
               end
            end
            MODE_ESC: begin
               case (c)
                  "n":     esc_val = 8'd10;
                  "r":     esc_val = 8'd13;
                  "t":     esc_val = 8'd9;
                  "\\":    esc_val = "\\";
                  "\"":    esc_val = "\"";
                  default: esc_val = 8'h00;
               endcase
               put_result(RT_VALUE, esc_val, KIND_NONE, ERR_NONE);
               lex_mode = MODE_STR;
            end
            MODE_CMT: begin
               if (c == 8'd13 || c == 8'd10) lex_mode = MODE_IDLE;
            end
            MODE_OP: begin
               pair_kind = KIND_NONE;
               paired    = 1'b0;
               if (c == "=") begin
                  paired = 1'b1;
                  case (pend_op)
                     "+":     pair_kind = KIND_PLUS_EQ;
                     "-":     pair_kind = KIND_MINUS_EQ;
                     "*":     pair_kind = KIND_STAR_EQ;
                     "/":     pair_kind = KIND_SLASH_EQ;
                     "=":     pair_kind = KIND_EQ;
                     ">":     pair_kind = KIND_GE;
                     "<":     pair_kind = KIND_LE;
                     "!":     pair_kind = KIND_NOT_EQ;
                     default: paired = 1'b0;
                  endcase
               end else if (pend_op == "<" && c == ">") begin
                  paired    = 1'b1;
                  pair_kind = KIND_NE_ANGLE;
               end else if (pend_op == "&" && c == "&") begin
                  paired    = 1'b1;
                  pair_kind = KIND_AND;
               end else if (pend_op == "|" && c == "|") begin
                  paired    = 1'b1;
                  pair_kind = KIND_OR;
               end
               if (paired) begin
                  put_result(RT_END, 8'h00, pair_kind, ERR_NONE);
                  clear_token_state();
               end else begin
                  flush_pending_op();
                  idle_take(c);
               end
            end
            default: begin
               lex_mode = MODE_IDLE;
               idle_take(c);
            end
         endcase
      end
      for (int i = 0; i < step_results.size(); i++) begin
         r      = step_results[i];
         r.last = (i == step_results.size() - 1);
         token_results.push_back(r);
      end
      step_results.delete();
   endfunction

   // ---------------------------------------------------------------
   // Driver: source bytes out of the pending queue, with random gaps
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      src_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
         clear_token_state();
         text_done = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            lex_step(req_tdata, req_tlast);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               nxt = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.in_byte;
               req_tlast  <= nxt.end_of_text;
               if (accepted_count + 30 < total_bytes && $urandom_range(0, 4) == 0)
                  send_gap = $urandom_range(1, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: score each result transaction, stall in random bursts
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.result_type = rsp_tuser;
            got.value_byte  = rsp_tdata[7:0];
            got.token_kind  = rsp_tdata[13:8];
            got.error_code  = rsp_tdata[15:14];
            got.last        = rsp_tlast;
            if (token_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result type=%0d value=%02h kind=%0d err=%0d last=%0b",
                        $time, got.result_type, got.value_byte, got.token_kind,
                        got.error_code, got.last);
            end else begin
               want = token_results.pop_front();
               if (got.result_type !== want.result_type || got.value_byte !== want.value_byte ||
                   got.token_kind !== want.token_kind || got.error_code !== want.error_code ||
                   got.last !== want.last) begin
                  fail_count++;
                  $display("%0t: expected type=%0d value=%02h kind=%0d err=%0d last=%0b",
                           $time, want.result_type, want.value_byte, want.token_kind,
                           want.error_code, want.last);
                  $display("%0t: actual   type=%0d value=%02h kind=%0d err=%0d last=%0b",
                           $time, got.result_type, got.value_byte, got.token_kind,
                           got.error_code, got.last);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (accepted_count + 30 < total_bytes && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------
   task automatic add_byte(logic [7:0] b, logic eot = 1'b0);
      src_item_type it;
      it.in_byte     = b;
      it.end_of_text = eot;
      pending_bytes.push_back(it);
   endtask

   task automatic add_text(string text);
      for (int i = 0; i < text.len(); i++) add_byte(text[i]);
   endtask

   function automatic logic [7:0] word_char();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range("a", "z"));
         1:       return 8'($urandom_range("A", "Z"));
         2:       return 8'($urandom_range("0", "9"));
         default: return "_";
      endcase
   endfunction

   // One well-formed token with random content, or some noise.
   task automatic add_token();
      string      op_text[21] = '{"+", "+=", "-", "-=", "*", "*=", "/", "/=", "=", "==", ">",
                                  ">=", "<", "<>", "<=", "&&", "||", "!", "!=", "&", "|"};
      string      punct_text = ",(){};%";
      string      esc_text = "nrt\\\"";
      int         k;
      int         n;
      logic [7:0] b;
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            // keyword, sometimes stretched into a longer identifier
            k = $urandom_range(0, KW_COUNT - 1);
            for (int p = 0; p < KW_LEN[k]; p++) add_byte(KW_TEXT[k][p]);
            if ($urandom_range(0, 3) == 0) begin
               n = $urandom_range(1, 3);
               for (int i = 0; i < n; i++) add_byte(word_char());
            end
         end
         3: begin
            b = word_char();
            add_byte(is_digit(b) ? 8'($urandom_range("a", "z")) : b);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) add_byte(word_char());
         end
         4: begin
            add_byte(8'($urandom_range("0", "9")));
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
               add_byte($urandom_range(0, 4) == 0 ? "." : 8'($urandom_range("0", "9")));
         end
         5: begin
            add_byte("\"");
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 5))
                  0: begin
                     add_byte("\\");
                     add_byte($urandom_range(0, 1) ? 8'(esc_text[$urandom_range(0, 4)])
                                                   : 8'($urandom_range(0, 255)));
                  end
                  1: begin
                     b = 8'($urandom_range(1, 255));
                     add_byte((b == "\"" || b == "\\") ? "x" : b);
                  end
                  default: begin
                     b = 8'($urandom_range(32, 126));
                     add_byte((b == "\"" || b == "\\") ? " " : b);
                  end
               endcase
            end
            add_byte("\"");
         end
         6, 7: add_text(op_text[$urandom_range(0, 20)]);
         8: add_byte(punct_text[$urandom_range(0, 6)]);
         9: begin
            add_byte("#");
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
               b = 8'($urandom_range(0, 255));
               add_byte((b == 8'd10 || b == 8'd13) ? "#" : b);
            end
            add_byte($urandom_range(0, 1) ? 8'd10 : 8'd13);
         end
         default: add_byte(8'($urandom_range(0, 255)));
      endcase
      // Separator, or none so that neighboring tokens touch.
      case ($urandom_range(0, 4))
         0:       add_byte(" ");
         1:       add_byte(8'($urandom_range(9, 13)));
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------
   // Run control
   // ---------------------------------------------------------------
   initial begin : run_control
      string tail_ops = "+-*/=><!&|";
      int    wait_cycles;
      int    extra;

      // Directed opening: keyword, float with several points, lone ampersand,
      // less-or-equal, escapes incl. an unknown one and a quote, comment with
      // a high byte, NUL and a lone point.
      add_text("for ");
      add_text("9..&x<=");
      add_text("\"\\q\\\"n\"");
      add_byte("#");
      add_byte(8'hFF);
      add_byte(8'd10);
      add_byte(8'h00);
      add_text(".");

      while (pending_bytes.size() < 100) add_token();

      // Leave a random kind of token open when the text ends.
      add_byte(" ");
      case ($urandom_range(0, 6))
         0: ;
         1: add_text("ab");
         2: add_text("7.");
         3: add_text("\"ab");
         4: add_text("\"a\\");
         5: add_text("#xx");
         default: add_byte(tail_ops[$urandom_range(0, 9)]);
      endcase
      add_byte(8'($urandom_range(0, 255)), 1'b1);

      // Items after the end of text only report end of file.
      extra = $urandom_range(3, 6);
      for (int i = 0; i < extra; i++)
         add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      total_bytes = pending_bytes.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_tvalid) @(negedge clock);
      wait_cycles = 0;
      while (token_results.size() != 0 && wait_cycles < 2000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (10) @(negedge clock);
      if (token_results.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected results never arrived", $time, token_results.size());
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #1000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
